// File: hdl/radio_time_code_frame_gen_unit_macros.svh
// Assertion macros for the checker file of the time code generator.
`ifndef RADIO_TIME_CODE_FRAME_GEN_UNIT_MACROS_SVH
`define RADIO_TIME_CODE_FRAME_GEN_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTCFG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTCFG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/rtcfg_pkg.sv
`default_nettype none
package rtcfg_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_BUSY    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SYM_BLANK = 2'd0,
    SYM_ZERO  = 2'd1,
    SYM_ONE   = 2'd2,
    SYM_MARK  = 2'd3
  } sym_e;

  typedef enum logic [2:0] {
    REG_TICKS_PER_SECOND = 3'd0,
    REG_ZERO_CYCLES      = 3'd1,
    REG_ONE_CYCLES       = 3'd2,
    REG_MARKER_CYCLES    = 3'd3
  } reg_idx_e;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned TpsW      = 10;
  localparam int unsigned CycW      = 8;

  localparam logic [TpsW-1:0] TpsReset    = 10'd200;
  localparam logic [TpsW-1:0] TpsMin      = 10'd2;
  localparam logic [CycW-1:0] ZeroReset   = 8'd18;
  localparam logic [CycW-1:0] OneReset    = 8'd48;
  localparam logic [CycW-1:0] MarkerReset = 8'd78;

  localparam logic [5:0] MaxMinute  = 6'd59;
  localparam logic [4:0] MaxHour    = 5'd23;
  localparam logic [8:0] MaxDay     = 9'd366;
  localparam logic [5:0] LastSecond = 6'd59;

  typedef struct packed {
    logic [3:0] year_digit;
    logic [3:0] minute_ones;
    logic [2:0] minute_tens;
    logic [3:0] hour_unit_dig;
    logic [2:0] hour_ten_dig;
    logic [3:0] day_unit_dig;
    logic [3:0] day_ten_dig;
    logic [1:0] day_hundreds;
  } digits_t;

  typedef struct packed {
    logic [TpsW-1:0] ticks_per_second;
    logic [CycW-1:0] zero_cycles;
    logic [CycW-1:0] one_cycles;
    logic [CycW-1:0] marker_cycles;
  } cfg_t;

  // Quotient by ten through a reciprocal multiply; exact for all 10-bit inputs.
  function automatic logic [6:0] div10(input logic [9:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd205;
    return p[17:11];
  endfunction

  // Quotient by one hundred; exact for all 9-bit inputs.
  function automatic logic [2:0] div100(input logic [8:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd41;
    return p[14:12];
  endfunction

  function automatic sym_e bit_sym(input logic b);
    return b ? SYM_ONE : SYM_ZERO;
  endfunction

  // Symbol carried by each second of the frame.
  function automatic sym_e symbol_of(input logic [5:0] s, input digits_t d);
    sym_e r;
    case (s) inside
      6'd0:           r = SYM_BLANK;
      [6'd1:6'd3]:    r = SYM_ZERO;
      [6'd4:6'd7]:    r = bit_sym(d.year_digit[2'(s - 6'd4)]);
      6'd8:           r = SYM_ZERO;
      6'd9:           r = SYM_MARK;
      [6'd10:6'd13]:  r = bit_sym(d.minute_ones[2'(s - 6'd10)]);
      6'd14:          r = SYM_ZERO;
      [6'd15:6'd17]:  r = bit_sym(d.minute_tens[2'(s - 6'd15)]);
      6'd18:          r = SYM_ZERO;
      6'd19:          r = SYM_MARK;
      [6'd20:6'd23]:  r = bit_sym(d.hour_unit_dig[2'(s - 6'd20)]);
      6'd24:          r = SYM_ZERO;
      [6'd25:6'd27]:  r = bit_sym(d.hour_ten_dig[2'(s - 6'd25)]);
      6'd28:          r = SYM_ZERO;
      6'd29:          r = SYM_MARK;
      [6'd30:6'd33]:  r = bit_sym(d.day_unit_dig[2'(s - 6'd30)]);
      6'd34:          r = SYM_ZERO;
      [6'd35:6'd38]:  r = bit_sym(d.day_ten_dig[2'(s - 6'd35)]);
      6'd39:          r = SYM_MARK;
      [6'd40:6'd41]:  r = bit_sym(d.day_hundreds[1'(s - 6'd40)]);
      [6'd42:6'd44]:  r = SYM_ZERO;
      default:        r = SYM_BLANK;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rtcfg_digits.sv
`default_nettype none
module rtcfg_digits (
  input  wire logic [5:0]       minute_i,
  input  wire logic [4:0]       hour_i,
  input  wire logic [8:0]       day_of_year_i,
  input  wire logic [7:0]       year_since_1900_i,
  output rtcfg_pkg::digits_t    digits_o,
  output logic                  date_ok_o
);
  import rtcfg_pkg::*;

  logic [6:0] min_q10, hr_q10, yr_q10, day_q10;
  logic [2:0] day_q100;
  logic [9:0] min_rem, hr_rem, yr_rem, day_rem;
  logic [8:0] day_rem100;

  // The year offset 1900 is a multiple of ten, so the units digit comes
  // straight from the offset.
  always_comb begin
    min_q10    = div10(10'(minute_i));
    hr_q10     = div10(10'(hour_i));
    yr_q10     = div10(10'(year_since_1900_i));
    day_q100   = div100(day_of_year_i);
    day_rem100 = day_of_year_i - 9'(day_q100) * 9'd100;
    day_q10    = div10(10'(day_rem100));
    min_rem    = 10'(minute_i) - 10'(min_q10) * 10'd10;
    hr_rem     = 10'(hour_i) - 10'(hr_q10) * 10'd10;
    yr_rem     = 10'(year_since_1900_i) - 10'(yr_q10) * 10'd10;
    day_rem    = 10'(day_rem100) - 10'(day_q10) * 10'd10;

    digits_o.year_digit    = yr_rem[3:0];
    digits_o.minute_ones   = min_rem[3:0];
    digits_o.minute_tens   = min_q10[2:0];
    digits_o.hour_unit_dig = hr_rem[3:0];
    digits_o.hour_ten_dig  = hr_q10[2:0];
    digits_o.day_unit_dig  = day_rem[3:0];
    digits_o.day_ten_dig   = day_q10[3:0];
    digits_o.day_hundreds  = day_q100[1:0];

    date_ok_o = (minute_i <= MaxMinute) && (hour_i <= MaxHour) && (day_of_year_i <= MaxDay);
  end
endmodule
`default_nettype wire

// File: hdl/rtcfg_symbol.sv
`default_nettype none
module rtcfg_symbol #(
  parameter int unsigned TICK_COUNT_WIDTH = 10
) (
  input  wire logic [5:0]                  second_i,
  input  wire logic [TICK_COUNT_WIDTH-1:0] tick_i,
  input  wire rtcfg_pkg::digits_t          digits_i,
  input  wire rtcfg_pkg::cfg_t             cfg_i,
  output logic                             pin_o
);
  import rtcfg_pkg::*;

  localparam int unsigned CmpW = ((TICK_COUNT_WIDTH > CycW + 1) ? TICK_COUNT_WIDTH
                                                                 : CycW + 1) + 1;

  sym_e            sym;
  logic [CycW-1:0] cyc;
  logic [CmpW-1:0] burst_ticks;

  always_comb begin
    sym = symbol_of(second_i, digits_i);
    unique case (sym)
      SYM_ZERO: cyc = cfg_i.zero_cycles;
      SYM_ONE:  cyc = cfg_i.one_cycles;
      SYM_MARK: cyc = cfg_i.marker_cycles;
      default:  cyc = '0;
    endcase
    // Each carrier cycle is one high tick followed by one low tick.
    burst_ticks = CmpW'({cyc, 1'b0});
    pin_o = (CmpW'(tick_i) < burst_ticks) && !tick_i[0];
  end
endmodule
`default_nettype wire

// File: hdl/radio_time_code_frame_gen_unit.sv
// Time code frame generator in the style of a radio time signal.
// Input channel (in_valid_i / in_ready_o): each transaction is either a load
// (operation 0) carrying minute, hour, day of year and year, or a tick
// (operation 1). A load checks the date and, when valid and idle, starts a
// 60 second frame. Each tick then produces one output level: a carrier burst
// at the start of each non-blank second whose length encodes a zero, a one or a
// position marker, followed by low level until the second ends.
// Output channel (out_valid_o / out_ready_i): exactly one result transaction
// per input transaction, in order, with the pin level, second index, active
// and frame end flags and the load status.
// Configuration: a plain write port (cfg_we_i, cfg_index_i, cfg_data_i) sets
// ticks per second and the burst lengths; the user must write it only while
// idle, since the block itself does not enforce this.
// A transaction passes through the input register and then the result
// register; a stall of the receiver can hold it in the input register.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the single pass through the digit split and the per-second symbol mux.
// Reset returns the registers to their defaults, clears the pipeline and
// leaves the generator idle. When the receiver stalls, the result register
// holds and the input register still takes one more transaction.
`default_nettype none
module radio_time_code_frame_gen_unit #(
  parameter int unsigned TICK_COUNT_WIDTH = 10
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rtcfg_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [rtcfg_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             operation_i,
  input  wire logic [5:0]                       minute_i,
  input  wire logic [4:0]                       hour_i,
  input  wire logic [8:0]                       day_of_year_i,
  input  wire logic [7:0]                       year_since_1900_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  pin_level_o,
  output logic [5:0]                            second_index_o,
  output logic                                  active_o,
  output logic                                  frame_end_o,
  output logic [1:0]                            status_o
);
  import rtcfg_pkg::*;

  localparam int unsigned CmpW = ((TICK_COUNT_WIDTH > TpsW) ? TICK_COUNT_WIDTH : TpsW) + 1;

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second <= TpsReset;
      cfg_q.zero_cycles      <= ZeroReset;
      cfg_q.one_cycles       <= OneReset;
      cfg_q.marker_cycles    <= MarkerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data_i[TpsW-1:0];
        REG_ZERO_CYCLES:      cfg_q.zero_cycles      <= cfg_data_i[CycW-1:0];
        REG_ONE_CYCLES:       cfg_q.one_cycles       <= cfg_data_i[CycW-1:0];
        REG_MARKER_CYCLES:    cfg_q.marker_cycles    <= cfg_data_i[CycW-1:0];
        default: begin
          // Unused indexes are ignored.
        end
      endcase
    end
  end

  // Input register stage.
  logic       s1_valid_q, s1_valid_d;
  logic       s1_op_q;
  logic [5:0] s1_minute_q;
  logic [4:0] s1_hour_q;
  logic [8:0] s1_day_q;
  logic [7:0] s1_year_q;
  logic       advance, in_accept, process;

  // The result register can take a new result when it is empty or being drained.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;
  assign process    = s1_valid_q && advance;

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q     <= operation_i;
      s1_minute_q <= minute_i;
      s1_hour_q   <= hour_i;
      s1_day_q    <= day_of_year_i;
      s1_year_q   <= year_since_1900_i;
    end
  end

  // Frame state.
  digits_t                     digits_q, digits_d, load_digits;
  logic [5:0]                  second_q, second_d;
  logic [TICK_COUNT_WIDTH-1:0] tick_q, tick_d;
  logic                        running_q, running_d;
  logic                        date_ok;
  logic                        burst_pin;

  rtcfg_digits u_digits (
    .minute_i          (s1_minute_q),
    .hour_i            (s1_hour_q),
    .day_of_year_i     (s1_day_q),
    .year_since_1900_i (s1_year_q),
    .digits_o          (load_digits),
    .date_ok_o         (date_ok)
  );

  rtcfg_symbol #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_symbol (
    .second_i (second_q),
    .tick_i   (tick_q),
    .digits_i (digits_q),
    .cfg_i    (cfg_q),
    .pin_o    (burst_pin)
  );

  // Result values for the transaction in the input register.
  logic            pin_d, active_d, frame_end_d;
  logic [5:0]      sec_out_d;
  status_e         status_d;
  logic [TpsW-1:0] tps_eff;
  logic [CmpW-1:0] tick_next_wide;
  logic            second_done;

  always_comb begin
    digits_d    = digits_q;
    second_d    = second_q;
    tick_d      = tick_q;
    running_d   = running_q;
    pin_d       = 1'b0;
    active_d    = 1'b0;
    frame_end_d = 1'b0;
    status_d    = STATUS_OK;
    sec_out_d   = '0;

    // A seconds setting below two behaves as two.
    tps_eff        = (cfg_q.ticks_per_second < TpsMin) ? TpsMin : cfg_q.ticks_per_second;
    tick_next_wide = CmpW'(tick_q) + CmpW'(1);
    second_done    = tick_next_wide >= CmpW'(tps_eff);

    if (s1_op_q == OP_LOAD) begin
      if (running_q) begin
        status_d = STATUS_BUSY;
      end else if (!date_ok) begin
        status_d = STATUS_INVALID;
      end else begin
        digits_d  = load_digits;
        second_d  = '0;
        tick_d    = '0;
        running_d = 1'b1;
      end
      sec_out_d = second_d;
      active_d  = running_d;
    end else if (running_q) begin
      pin_d     = burst_pin;
      sec_out_d = second_q;
      active_d  = 1'b1;
      if (second_done) begin
        tick_d = '0;
        if (second_q >= LastSecond) begin
          frame_end_d = 1'b1;
          second_d    = '0;
          running_d   = 1'b0;
        end else begin
          second_d = second_q + 6'd1;
        end
      end else begin
        tick_d = tick_next_wide[TICK_COUNT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q  <= '0;
      second_q  <= '0;
      tick_q    <= '0;
      running_q <= 1'b0;
    end else if (process) begin
      digits_q  <= digits_d;
      second_q  <= second_d;
      tick_q    <= tick_d;
      running_q <= running_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (process) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      pin_level_o    <= pin_d;
      second_index_o <= sec_out_d;
      active_o       <= active_d;
      frame_end_o    <= frame_end_d;
      status_o       <= status_d;
    end
  end
endmodule
`default_nettype wire

// File: hdl/rtcfg_checker.sv
`default_nettype none
`include "radio_time_code_frame_gen_unit_macros.svh"
module rtcfg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_we_i,
  input wire logic [2:0] cfg_index_i,
  input wire logic [9:0] cfg_data_i,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       operation_i,
  input wire logic [5:0] minute_i,
  input wire logic [4:0] hour_i,
  input wire logic [8:0] day_of_year_i,
  input wire logic [7:0] year_since_1900_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       pin_level_o,
  input wire logic [5:0] second_index_o,
  input wire logic       active_o,
  input wire logic       frame_end_o,
  input wire logic [1:0] status_o
);
  import rtcfg_pkg::*;

  // A stalled result holds its payload.
  `RTCFG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(second_index_o) && $stable(pin_level_o) && $stable(status_o))

  // The frame ends only on the last second of an active frame.
  `RTCFG_ASSERT_IMP(a_frame_end, clk_i, rst_ni, out_valid_o && frame_end_o,
    active_o && second_index_o == LastSecond && status_o == STATUS_OK)

  // Outside a frame the line is low and the second index is zero.
  `RTCFG_ASSERT_IMP(a_idle_quiet, clk_i, rst_ni, out_valid_o && !active_o,
    !pin_level_o && !frame_end_o && second_index_o == 6'd0)

  // A refused load carries a busy or invalid status and never drives the line.
  `RTCFG_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o && status_o != STATUS_OK,
    status_o <= STATUS_BUSY && !pin_level_o && !frame_end_o)
endmodule

bind radio_time_code_frame_gen_unit rtcfg_checker u_rtcfg_checker (.*);
`default_nettype wire
